@@ design/tts_pkg.sv @@
// ----------------------------------------------------------------------------
// tts_pkg
// Shared sizes, kind codes and controller/datapath bundles for the tick
// scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int TASK_SLOTS  = 8;
  localparam int MAX_RESULTS = 8;

  localparam int KIND_W   = 3;
  localparam int TSLOT_W  = 3;
  localparam int PERIOD_W = 16;
  localparam int DELAY_W  = 8;

  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SUSPEND = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESUME  = 3'd4;

  localparam logic RES_CREATE = 1'b0;
  localparam logic RES_FIRE   = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic apply;        // apply create/delete/suspend/resume from the input beat
    logic scan_start;   // clear scan index and fire count
    logic scan_step;    // update the slot under the scan index, advance
    logic emit_create;  // load create status into the output register
    logic emit_fire;    // load fire event into the output register
  } tts_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;     // output register can take a beat this cycle
    logic need_emit;    // slot under scan index fires and is reported
    logic scan_end;     // scan index is on the last slot
  } tts_stat_t;

endpackage

@@ design/tts_ctrl.sv @@
// ----------------------------------------------------------------------------
// tts_ctrl
// Sequencer: takes one input beat at a time, walks the slot scan on ticks
// and hands out create status and fire beats.
// ----------------------------------------------------------------------------
module tts_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [tts_pkg::KIND_W-1:0] in_kind,
  output logic                       in_stall,
  output tts_pkg::tts_cmd_t          cmd,
  input  tts_pkg::tts_stat_t         stat
);
  import tts_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_TICK) begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end else begin
            cmd.apply = 1'b1;
            if (in_kind == KIND_CREATE) begin
              state_nxt = ST_RESP;
            end
          end
        end
      end
      ST_SCAN: begin
        // hold the slot while a reported fire cannot be placed
        if (!(stat.need_emit && !stat.out_free)) begin
          cmd.scan_step = 1'b1;
          cmd.emit_fire = stat.need_emit;
          if (stat.scan_end) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RESP: begin
        if (stat.out_free) begin
          cmd.emit_create = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a tick always ends its scan before another beat is taken
  a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && cmd.scan_step && stat.scan_end) |=> (state_r == ST_IDLE))
    else $error("scan did not return to idle after last slot");

endmodule

@@ design/tts_dp.sv @@
// ----------------------------------------------------------------------------
// tts_dp
// Slot table, scan index, fire counter and output register.
// ----------------------------------------------------------------------------
module tts_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tts_pkg::tts_cmd_t            cmd,
  output tts_pkg::tts_stat_t           stat,
  input  logic [tts_pkg::KIND_W-1:0]   in_kind,
  input  logic [tts_pkg::TSLOT_W-1:0]  in_task_slot,
  input  logic [tts_pkg::PERIOD_W-1:0] in_period,
  input  logic [tts_pkg::DELAY_W-1:0]  in_first_delay,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_result_kind,
  output logic                         out_create_ok,
  output logic [tts_pkg::TSLOT_W-1:0]  out_fired_slot,
  output logic                         out_last
);
  import tts_pkg::*;

  logic [TASK_SLOTS-1:0]     valid_r;
  logic [TASK_SLOTS-1:0]     running_r;
  logic [PERIOD_W-1:0]       period_r [TASK_SLOTS];
  logic [PERIOD_W-1:0]       cd_r     [TASK_SLOTS];

  logic [SLOT_W-1:0]         idx_r;
  logic [CNT_W-1:0]          fire_cnt_r;
  logic                      create_ok_r;

  logic                      out_valid_r;
  logic                      out_kind_r;
  logic                      out_ok_r;
  logic [TSLOT_W-1:0]        out_slot_r;
  logic                      out_last_r;

  logic [TASK_SLOTS-1:0]     due;
  logic                      due_above;
  logic                      fire_last;
  logic [SLOT_W-1:0]         sel;
  logic                      in_range;
  logic                      create_hit;

  assign sel        = SLOT_W'(in_task_slot);
  assign in_range   = (32'(in_task_slot) < TASK_SLOTS);
  assign create_hit = in_range && !valid_r[sel];

  // due flags from the table as it stood at tick start (slots above the
  // scan index are untouched until the scan reaches them)
  always_comb begin
    due_above = 1'b0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      due[i] = valid_r[i] && running_r[i] && (cd_r[i] == '0);
      if ((SLOT_W'(i) > idx_r) && due[i]) begin
        due_above = 1'b1;
      end
    end
  end

  assign fire_last = !due_above || (fire_cnt_r == CNT_W'(MAX_RESULTS - 1));

  assign stat.out_free  = !out_valid_r || !out_stall;
  assign stat.need_emit = due[idx_r] && (fire_cnt_r < CNT_W'(MAX_RESULTS));
  assign stat.scan_end  = (idx_r == SLOT_W'(TASK_SLOTS - 1));

  // slot table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      running_r <= '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        period_r[i] <= '0;
        cd_r[i]     <= '0;
      end
    end else if (cmd.apply) begin
      unique case (in_kind)
        KIND_CREATE: begin
          if (create_hit) begin
            valid_r[sel]   <= 1'b1;
            running_r[sel] <= 1'b1;
            period_r[sel]  <= in_period;
            cd_r[sel]      <= PERIOD_W'(in_first_delay);
          end
        end
        KIND_DELETE:  if (in_range) valid_r[sel]   <= 1'b0;
        KIND_SUSPEND: if (in_range) running_r[sel] <= 1'b0;
        KIND_RESUME:  if (in_range) running_r[sel] <= 1'b1;
        default: ;
      endcase
    end else if (cmd.scan_step && running_r[idx_r]) begin
      if (cd_r[idx_r] == '0) begin
        if (valid_r[idx_r]) begin
          cd_r[idx_r] <= period_r[idx_r] - PERIOD_W'(1);
        end
      end else begin
        cd_r[idx_r] <= cd_r[idx_r] - PERIOD_W'(1);
      end
    end
  end

  // scan index and fire count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      fire_cnt_r <= '0;
    end else if (cmd.scan_start) begin
      idx_r      <= '0;
      fire_cnt_r <= '0;
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + SLOT_W'(1);
      if (cmd.emit_fire) begin
        fire_cnt_r <= fire_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && in_kind == KIND_CREATE) begin
      create_ok_r <= create_hit;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_create || cmd.emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_fire) begin
      out_kind_r <= RES_FIRE;
      out_ok_r   <= 1'b0;
      out_slot_r <= TSLOT_W'(idx_r);
      out_last_r <= fire_last;
    end else if (cmd.emit_create) begin
      out_kind_r <= RES_CREATE;
      out_ok_r   <= create_ok_r;
      out_slot_r <= '0;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_create_ok   = out_ok_r;
  assign out_fired_slot  = out_slot_r;
  assign out_last        = out_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_create || cmd.emit_fire) |-> stat.out_free)
    else $error("output beat overwritten while stalled");

  a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fire_cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("fire count past result limit");

  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step && cmd.emit_fire) |=>
      (cd_r[$past(idx_r)] == $past(period_r[idx_r]) - PERIOD_W'(1)))
    else $error("fired slot not reloaded");

endmodule

@@ design/periodic_task_tick_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_core
// Create/delete/suspend/resume: applied when taken; a create then places its status
// beat once the output register is free. Tick: scans one slot per cycle over all
// TASK_SLOTS (8) slots, holding on a fire beat that a stalled output cannot take.
// One beat at a time: input stalls until a tick's scan or a create's status is done.
// Reset (synchronous, rst_n low): all slots cleared, sequencer idle, no output.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tts_pkg::KIND_W-1:0]   in_kind,
  input  logic [tts_pkg::TSLOT_W-1:0]  in_task_slot,
  input  logic [tts_pkg::PERIOD_W-1:0] in_period,
  input  logic [tts_pkg::DELAY_W-1:0]  in_first_delay,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_result_kind,
  output logic                         out_create_ok,
  output logic [tts_pkg::TSLOT_W-1:0]  out_fired_slot,
  output logic                         out_last
);
  import tts_pkg::*;

  // Controller owns the handshake on the input side and the scan sequence;
  // datapath owns the slot table and a single output register. The scan
  // holds on a slot whose fire beat cannot yet be placed, so a stalled
  // output simply stretches the tick.
  tts_cmd_t  cmd;
  tts_stat_t stat;

  tts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // The last flag of a fire beat comes from the due flags of the slots
  // above the scan index, so no look-ahead beat is buffered.
  tts_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_kind),
    .in_task_slot    (in_task_slot),
    .in_period       (in_period),
    .in_first_delay  (in_first_delay),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_create_ok   (out_create_ok),
    .out_fired_slot  (out_fired_slot),
    .out_last        (out_last)
  );

endmodule
